// ----- design/plti_pkg.sv -----
// Package for the piecewise linear table interpolator.
// Holds table depth, field widths and operation/status codes.
// No dependencies; imported by every module of the block except the generic RAM.
`default_nettype none

package plti_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Field widths
	localparam int ENTRY_IDX_W = 8;
	localparam int CFG_W       = 9;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 40;
	localparam int MAG_W       = VAL_W + 1;
	localparam int PROD_W      = MAG_W + KEY_W;
	localparam int STEP_W      = $clog2(MAG_W);

	// Stream payload widths
	localparam int S_TDATA_W = ENTRY_IDX_W + KEY_W + VAL_W;
	localparam int M_TDATA_W = VAL_W;

	// Minimum breakpoint count and count after reset
	localparam int MIN_ENTRIES = 2;
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(MIN_ENTRIES);

	// Operation codes carried on s_tuser
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Status codes carried on m_tuser
	localparam logic STAT_OK    = 1'b0;
	localparam logic STAT_RANGE = 1'b1;

endpackage : plti_pkg

`default_nettype wire

// ----- design/plti_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the breakpoint key and value tables. No dependencies.
`default_nettype none

module plti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule : plti_ram

`default_nettype wire

// ----- design/plti_muldiv.sv -----
// Bit-serial multiply-then-divide unit: quo = floor(mag * num / den).
// One shared adder does the shift-add multiply and the restoring divide.
// Depends on plti_pkg. Requires num <= den so the quotient fits in MAG_W bits.
`default_nettype none

module plti_muldiv (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [plti_pkg::MAG_W-1:0]  mag,
	input  wire logic [plti_pkg::KEY_W-1:0]  num,
	input  wire logic [plti_pkg::KEY_W-1:0]  den,
	output logic                             done,
	output logic      [plti_pkg::MAG_W-1:0]  quo
);
	import plti_pkg::*;

	typedef enum logic [2:0] {
		MD_IDLE = 3'b001,
		MD_MUL  = 3'b010,
		MD_DIV  = 3'b100
	} md_state_t;

	md_state_t          state_q;
	logic [STEP_W-1:0]  step_q;
	logic               done_q;
	logic [PROD_W-1:0]  prod_q;
	logic [MAG_W-1:0]   mag_q;
	logic [KEY_W-1:0]   den_q;

	// Shared adder: mag add in multiply, trial subtract of den in divide
	logic [MAG_W:0] add_a;
	logic [MAG_W:0] add_b;
	logic           add_cin;
	logic [MAG_W:0] add_sum;
	logic           qbit;

	always_comb begin
		if (state_q == MD_DIV) begin
			add_a   = (MAG_W+1)'(prod_q[PROD_W-1:MAG_W-1]);
			add_b   = ~((MAG_W+1)'(den_q));
			add_cin = 1'b1;
		end else begin
			add_a   = {1'b0, prod_q[PROD_W-1:KEY_W]};
			add_b   = {1'b0, mag_q};
			add_cin = 1'b0;
		end
		add_sum = add_a + add_b + (MAG_W+1)'(add_cin);
		qbit    = ~add_sum[MAG_W];
	end

	// Control: MUL runs KEY_W steps, DIV runs MAG_W steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == MD_DIV) && (step_q == STEP_W'(MAG_W - 1));
			case (state_q)
				MD_IDLE: begin
					if (start) begin
						state_q <= MD_MUL;
						step_q  <= '0;
					end
				end
				MD_MUL: begin
					if (step_q == STEP_W'(KEY_W - 1)) begin
						state_q <= MD_DIV;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				MD_DIV: begin
					if (step_q == STEP_W'(MAG_W - 1)) begin
						state_q <= MD_IDLE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				default: begin
					state_q <= MD_IDLE;
				end
			endcase
		end
	end

	// Datapath: product shifts right while multiplying; remainder/quotient shift left
	// while dividing (remainder in the top KEY_W bits, quotient enters at bit 0)
	always_ff @(posedge clk) begin
		case (state_q)
			MD_IDLE: begin
				if (start) begin
					prod_q <= PROD_W'(num);
					mag_q  <= mag;
					den_q  <= den;
				end
			end
			MD_MUL: begin
				if (prod_q[0]) begin
					prod_q <= {add_sum, prod_q[KEY_W-1:1]};
				end else begin
					prod_q <= {1'b0, prod_q[PROD_W-1:1]};
				end
			end
			MD_DIV: begin
				prod_q <= {(qbit ? add_sum[KEY_W-1:0] : prod_q[PROD_W-2:MAG_W-1]),
					prod_q[MAG_W-2:0], qbit};
			end
			default: begin
				prod_q <= prod_q;
			end
		endcase
	end

	assign done = done_q;
	assign quo  = prod_q[MAG_W-1:0];

endmodule : plti_muldiv

`default_nettype wire

// ----- design/piecewise_linear_table_interpolator_unit.sv -----
// Piecewise linear table interpolator. A load transaction (s_tuser = 0) writes one
// breakpoint (key, value) and completes with no result. A query
// transaction (s_tuser = 1) returns one result: key zero gives zero, a key between
// two breakpoints is interpolated, a key outside the table gives status 1 and value
// zero. The block works on one item at a time and holds s_tready low while busy.
// An interpolated query is worked in order: the key table is scanned one entry per
// cycle through its single read port up to the first breakpoint not below the key,
// the value pair is read in ST_VLOW and ST_VHIGH, and the bit-serial multiply/divide
// unit then runs 32 multiply steps plus 41 divide steps before it hands back its
// result.
// Key zero and out-of-range keys finish as soon as they are detected.
// A finished result waits in the output register while the next item is accepted.
// Depends on plti_pkg, plti_ram and plti_muldiv.
`default_nettype none

module piecewise_linear_table_interpolator_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Configuration: entry_count
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [plti_pkg::CFG_W-1:0]      cfg_data,
	// Input stream
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [plti_pkg::S_TDATA_W-1:0]  s_tdata,   // entry_index, key, entry_value
	input  wire logic                            s_tuser,   // op
	// Output stream
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [plti_pkg::M_TDATA_W-1:0]  m_tdata,   // result_value
	output logic                                 m_tuser    // status
);
	import plti_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SEARCH = 6'b000010,
		ST_VLOW   = 6'b000100,
		ST_VHIGH  = 6'b001000,
		ST_CALC   = 6'b010000,
		ST_OUT    = 6'b100000
	} state_t;

	// Input field unpacking
	logic [ENTRY_IDX_W-1:0] in_entry_index;
	logic [KEY_W-1:0]       in_key;
	logic [VAL_W-1:0]       in_entry_value;

	assign in_entry_index = s_tdata[ENTRY_IDX_W-1:0];
	assign in_key         = s_tdata[ENTRY_IDX_W+KEY_W-1:ENTRY_IDX_W];
	assign in_entry_value = s_tdata[S_TDATA_W-1:ENTRY_IDX_W+KEY_W];

	state_t             state_q;
	logic [CFG_W-1:0]   cfg_count_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               first_q;
	logic               neg_q;
	logic [KEY_W-1:0]   key_q;
	logic [KEY_W-1:0]   prev_key_q;
	logic [KEY_W-1:0]   num_q;
	logic [KEY_W-1:0]   den_q;
	logic [VAL_W-1:0]   v0_q;
	logic [VAL_W-1:0]   res_val_q;
	logic               res_stat_q;
	logic               m_tvalid_q;
	logic [VAL_W-1:0]   m_tdata_q;
	logic               m_tuser_q;

	logic               in_txn;
	logic               ld_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [IDX_W-1:0]   key_raddr;
	logic [IDX_W-1:0]   val_raddr;
	logic [KEY_W-1:0]   key_rdata;
	logic [VAL_W-1:0]   val_rdata;
	logic [CNT_W-1:0]   n_used;
	logic [CNT_W-1:0]   cnt_next;
	logic               out_free;

	logic               md_start;
	logic               md_done;
	logic [MAG_W-1:0]   md_mag;
	logic [MAG_W-1:0]   md_quo;
	logic [VAL_W:0]     dv;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_txn    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign cnt_next  = cnt_q + 1'b1;

	// Clamp the breakpoint count to the table
	always_comb begin
		if (32'(cfg_count_q) < 32'(MIN_ENTRIES)) begin
			n_used = CNT_W'(MIN_ENTRIES);
		end else if (32'(cfg_count_q) > 32'(TABLE_DEPTH)) begin
			n_used = CNT_W'(TABLE_DEPTH);
		end else begin
			n_used = CNT_W'(cfg_count_q);
		end
	end

	// Table write on a load transaction
	assign ld_en   = in_txn && (s_tuser == OP_LOAD)
		&& (32'(in_entry_index) < 32'(TABLE_DEPTH));
	assign wr_addr = IDX_W'(in_entry_index);

	// Read addresses: keys scan ahead of the compare; values fetch pos-1 then pos
	always_comb begin
		key_raddr = '0;
		val_raddr = cnt_q[IDX_W-1:0];
		if (state_q == ST_SEARCH) begin
			key_raddr = cnt_next[IDX_W-1:0];
			val_raddr = IDX_W'(cnt_q - 1'b1);
		end
	end

	plti_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (ld_en),
		.waddr (wr_addr),
		.wdata (in_key),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	plti_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_val_ram (
		.clk   (clk),
		.we    (ld_en),
		.waddr (wr_addr),
		.wdata (in_entry_value),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	// Value difference and its magnitude for the multiply/divide unit
	assign dv       = {val_rdata[VAL_W-1], val_rdata} - {v0_q[VAL_W-1], v0_q};
	assign md_mag   = dv[VAL_W] ? (MAG_W'(0) - dv) : dv;
	assign md_start = (state_q == ST_VHIGH) && !first_q;

	plti_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.mag    (md_mag),
		.num    (num_q),
		.den    (den_q),
		.done   (md_done),
		.quo    (md_quo)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_count_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cfg_count_q <= cfg_data;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			first_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_txn && (s_tuser == OP_QUERY)) begin
						cnt_q   <= '0;
						first_q <= 1'b0;
						if (in_key == '0) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (key_q <= key_rdata) begin
						if (cnt_q == '0) begin
							first_q <= 1'b1;
							state_q <= (key_q == key_rdata) ? ST_VLOW : ST_OUT;
						end else begin
							state_q <= ST_VLOW;
						end
					end else if (cnt_next == n_used) begin
						state_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_next;
					end
				end
				ST_VLOW: begin
					state_q <= ST_VHIGH;
				end
				ST_VHIGH: begin
					state_q <= first_q ? ST_OUT : ST_CALC;
				end
				ST_CALC: begin
					if (md_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				key_q      <= in_key;
				res_val_q  <= '0;
				res_stat_q <= STAT_OK;
			end
			ST_SEARCH: begin
				prev_key_q <= key_rdata;
				num_q      <= key_q - prev_key_q;
				den_q      <= key_rdata - prev_key_q;
				if (key_q <= key_rdata) begin
					if ((cnt_q == '0) && (key_q != key_rdata)) begin
						res_stat_q <= STAT_RANGE;
					end
				end else if (cnt_next == n_used) begin
					res_stat_q <= STAT_RANGE;
				end
			end
			ST_VLOW: begin
				v0_q <= val_rdata;
			end
			ST_VHIGH: begin
				neg_q <= dv[VAL_W];
				if (first_q) begin
					res_val_q <= val_rdata;
				end
			end
			ST_CALC: begin
				if (md_done) begin
					res_val_q <= neg_q ? (v0_q - md_quo[VAL_W-1:0])
						: (v0_q + md_quo[VAL_W-1:0]);
				end
			end
			ST_OUT: begin
				if (out_free) begin
					m_tdata_q <= res_val_q;
					m_tuser_q <= res_stat_q;
				end
			end
			default: begin
				key_q <= key_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule : piecewise_linear_table_interpolator_unit

`default_nettype wire

// ----- bench/tb_piecewise_linear_table_interpolator_unit.sv -----
// Self-checking testbench for piecewise_linear_table_interpolator_unit.
// Loads breakpoint tables, queries interpolated values and checks every result against
// a typed-in expectation or a local interpolation predictor. Depends on plti_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_piecewise_linear_table_interpolator_unit;
	import plti_pkg::*;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             status;
	} interp_result_t;

	typedef struct {
		logic             op;
		logic [7:0]       idx;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
		bit               typed;     // expected result typed in below
		logic [VAL_W-1:0] want_val;
		logic             want_stat;
	} directed_row_t;

	localparam int HOLD_CYCLES = 1500;
	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES = 400;
	localparam int NUM_PHASES = 13;
	localparam int OPS_PER_PHASE = 50;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata;    // entry_index, key, entry_value
	logic s_tuser;                    // op
	logic m_tvalid;
	logic m_tready;
	logic [M_TDATA_W-1:0] m_tdata;    // result_value
	logic m_tuser;                    // status

	// Shadow of the block's state
	logic [KEY_W-1:0]        bp_key [TABLE_DEPTH];
	logic signed [VAL_W-1:0] bp_val [TABLE_DEPTH];
	bit                      bp_written [TABLE_DEPTH];
	logic [CFG_W-1:0]        active_entry_count;

	interp_result_t pending_results[$];
	int unsigned    fail_count;
	int unsigned    results_seen;
	bit             idling_on;

	// Directed stimulus; typed-in results are the obvious ones only
	directed_row_t directed_rows [25] = '{
		'{OP_LOAD,  8'd0,   32'h0010_0000, 40'h00_0001_0000, 1'b0, 40'h0, STAT_OK},
		'{OP_LOAD,  8'd1,   32'h0020_0000, 40'h00_0003_0000, 1'b0, 40'h0, STAT_OK},
		// key zero
		'{OP_QUERY, 8'd0,   32'h0000_0000, 40'h0, 1'b1, 40'h0, STAT_OK},
		// key equal to the first breakpoint
		'{OP_QUERY, 8'd0,   32'h0010_0000, 40'h0, 1'b1, 40'h00_0001_0000, STAT_OK},
		// below the first and above the last breakpoint
		'{OP_QUERY, 8'd0,   32'h0008_0000, 40'h0, 1'b1, 40'h0, STAT_RANGE},
		'{OP_QUERY, 8'd0,   32'h0030_0000, 40'h0, 1'b1, 40'h0, STAT_RANGE},
		'{OP_QUERY, 8'd0,   32'hFFFF_FFFF, 40'h0, 1'b1, 40'h0, STAT_RANGE},
		'{OP_QUERY, 8'd0,   32'h0018_0000, 40'h0, 1'b0, 40'h0, STAT_OK},
		'{OP_QUERY, 8'd0,   32'h0020_0000, 40'h0, 1'b0, 40'h0, STAT_OK},
		// full key span, value from min to max
		'{OP_LOAD,  8'd0,   32'h0000_0001, 40'h80_0000_0000, 1'b0, 40'h0, STAT_OK},
		'{OP_LOAD,  8'd1,   32'hFFFF_FFFF, 40'h7F_FFFF_FFFF, 1'b0, 40'h0, STAT_OK},
		'{OP_QUERY, 8'd0,   32'h0000_0001, 40'h0, 1'b1, 40'h80_0000_0000, STAT_OK},
		'{OP_QUERY, 8'd0,   32'hFFFF_FFFF, 40'h0, 1'b0, 40'h0, STAT_OK},
		'{OP_QUERY, 8'd0,   32'h8000_0000, 40'h0, 1'b0, 40'h0, STAT_OK},
		'{OP_QUERY, 8'd0,   32'h0000_0002, 40'h0, 1'b0, 40'h0, STAT_OK},
		// steepest falling slope at the top of the key range
		'{OP_LOAD,  8'd0,   32'hFFFF_FFFE, 40'h7F_FFFF_FFFF, 1'b0, 40'h0, STAT_OK},
		'{OP_LOAD,  8'd1,   32'hFFFF_FFFF, 40'h80_0000_0000, 1'b0, 40'h0, STAT_OK},
		'{OP_QUERY, 8'd0,   32'hFFFF_FFFF, 40'h0, 1'b0, 40'h0, STAT_OK},
		'{OP_QUERY, 8'd0,   32'hFFFF_FFFE, 40'h0, 1'b1, 40'h7F_FFFF_FFFF, STAT_OK},
		'{OP_QUERY, 8'd0,   32'h0000_0001, 40'h0, 1'b1, 40'h0, STAT_RANGE},
		// top table index
		'{OP_LOAD,  8'd255, 32'hA5A5_A5A5, 40'h5A_5A5A_5A5A, 1'b0, 40'h0, STAT_OK},
		// descending keys: the first entry already covers any smaller key
		'{OP_LOAD,  8'd0,   32'h0000_0100, 40'h00_0000_1000, 1'b0, 40'h0, STAT_OK},
		'{OP_LOAD,  8'd1,   32'h0000_0050, 40'hFF_FFFF_F000, 1'b0, 40'h0, STAT_OK},
		'{OP_QUERY, 8'd0,   32'h0000_0080, 40'h0, 1'b1, 40'h0, STAT_RANGE},
		'{OP_QUERY, 8'd0,   32'h0000_0200, 40'h0, 1'b1, 40'h0, STAT_RANGE}
	};

	// entry_count settings per phase, out-of-range values included
	int unsigned phase_counts [NUM_PHASES] = '{0, 5, 3, 1, 16, 2, 9, 256, 511, 300, 4, 64, 2};

	piecewise_linear_table_interpolator_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Breakpoints in use after clamping the register
	function automatic int unsigned entries_in_use();
		if (active_entry_count < MIN_ENTRIES)
			return MIN_ENTRIES;
		if (active_entry_count > TABLE_DEPTH)
			return TABLE_DEPTH;
		return 32'(active_entry_count);
	endfunction

	// Expected result of a query against the shadow table
	function automatic interp_result_t interpolate_at(logic [KEY_W-1:0] qkey);
		interp_result_t r;
		int unsigned n;
		int unsigned pos;
		int unsigned i;
		bit hit;
		longint v0;
		longint v1;
		longint dv;
		longint acc;
		logic [KEY_W-1:0] dk;
		logic [KEY_W-1:0] span;
		logic [127:0] mag;
		logic [127:0] num;
		logic [127:0] den;
		logic [127:0] quo;
		r.value = '0;
		r.status = STAT_OK;
		if (qkey == 0)
			return r;
		n = entries_in_use();
		hit = 1'b0;
		pos = 0;
		for (i = 0; i < n; i++) begin
			if (!hit && qkey <= bp_key[i]) begin
				hit = 1'b1;
				pos = i;
			end
		end
		if (!hit) begin
			r.status = STAT_RANGE;
			return r;
		end
		if (pos == 0) begin
			if (qkey == bp_key[0])
				r.value = bp_val[0];
			else
				r.status = STAT_RANGE;
			return r;
		end
		// v0 + trunc(dv * dk / span), exact in 128 bits
		v0 = longint'(bp_val[pos-1]);
		v1 = longint'(bp_val[pos]);
		dv = v1 - v0;
		dk = qkey - bp_key[pos-1];
		span = bp_key[pos] - bp_key[pos-1];
		mag = {64'd0, ((dv < 0) ? -dv : dv)};
		num = {96'd0, dk};
		den = {96'd0, span};
		quo = (mag * num) / den;
		acc = (dv < 0) ? v0 - longint'(quo[63:0]) : v0 + longint'(quo[63:0]);
		r.value = acc[VAL_W-1:0];
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] random_value();
		logic [7:0] top;
		int s;
		case ($urandom_range(0, 7))
			0: return 40'h7F_FFFF_FFFF;
			1: return 40'h80_0000_0000;
			2: begin
				s = int'($urandom_range(0, 2000)) - 1000;
				return 40'(s);
			end
			default: begin
				top = 8'($urandom_range(0, 255));
				return {top, 32'($urandom)};
			end
		endcase
	endfunction

	// Query keys aimed at the interesting regions of the table
	function automatic logic [KEY_W-1:0] random_query_key(int unsigned n);
		int unsigned i;
		logic [KEY_W-1:0] lo;
		logic [KEY_W-1:0] hi;
		case ($urandom_range(0, 9))
			0: return '0;
			1, 2: return bp_key[$urandom_range(0, n - 1)];
			3: begin
				if (bp_key[0] > 1)
					return $urandom_range(1, bp_key[0] - 1);
				return 32'd1;
			end
			4: begin
				lo = bp_key[n-1];
				if (lo != 32'hFFFF_FFFF)
					return $urandom_range(lo + 1, 32'hFFFF_FFFF);
				return lo;
			end
			5: return $urandom;
			default: begin
				i = $urandom_range(1, n - 1);
				lo = bp_key[i-1];
				hi = bp_key[i];
				if (hi > lo)
					return lo + 1 + ($urandom % (hi - lo));
				return $urandom;
			end
		endcase
	endfunction

	// One input transaction; called and returns at a falling edge
	task automatic send_item(input logic op, input logic [7:0] idx,
			input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] val,
			input bit typed, input interp_result_t typed_result);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {val, key, idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (op == OP_QUERY) begin
			pending_results.push_back(typed ? typed_result : interpolate_at(key));
		end else begin
			bp_key[idx] = key;
			bp_val[idx] = val;
			bp_written[idx] = 1'b1;
		end
		@(negedge clk);
	endtask

	// Stop offering, let every result come back and the block go idle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_entry_count(input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		active_entry_count = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Non-decreasing breakpoints in entries 0..n-1, narrow or wide spacing
	task automatic fill_table(input int unsigned n);
		int unsigned i;
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] max_step;
		if ($urandom_range(0, 1))
			max_step = 32'hFFFF_FFF0 / (n + 1);
		else
			max_step = $urandom_range(1, 4096);
		k = ($urandom_range(0, 7) == 0) ? '0 : $urandom_range(0, max_step);
		for (i = 0; i < n; i++) begin
			send_item(OP_LOAD, 8'(i), k, random_value(), 1'b0, '0);
			k = k + $urandom_range(($urandom_range(0, 9) == 0) ? 0 : 1, max_step);
		end
	endtask

	// Stimulus
	initial begin : stimulus
		int unsigned r;
		int unsigned ph;
		int unsigned op_i;
		int unsigned n;
		int unsigned i;
		bit refill;
		interp_result_t typed_result;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_LOAD;
		fail_count = 0;
		results_seen = 0;
		idling_on = 1'b1;
		active_entry_count = CFG_RESET;
		for (i = 0; i < TABLE_DEPTH; i++)
			bp_written[i] = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (r = 0; r < $size(directed_rows); r++) begin
			typed_result.value = directed_rows[r].want_val;
			typed_result.status = directed_rows[r].want_stat;
			send_item(directed_rows[r].op, directed_rows[r].idx, directed_rows[r].key,
				directed_rows[r].val, directed_rows[r].typed, typed_result);
		end

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			if (ph == NUM_PHASES - 1)
				idling_on = 1'b0;
			write_entry_count(CFG_W'(phase_counts[ph]));
			n = entries_in_use();
			refill = (n <= 32);
			for (i = 0; i < n; i++)
				if (!bp_written[i])
					refill = 1'b1;
			if (refill)
				fill_table(n);
			// mostly queries, with stray loads that may break the ordering
			for (op_i = 0; op_i < OPS_PER_PHASE; op_i++) begin
				if ($urandom_range(0, 6) == 0)
					send_item(OP_LOAD, 8'($urandom_range(0, 255)), $urandom,
						random_value(), 1'b0, '0);
				else
					send_item(OP_QUERY, 8'($urandom_range(0, 255)), random_query_key(n),
						random_value(), 1'b0, '0);
			end
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[piecewise_linear_table_interpolator_unit] OK");
		else
			$display("[piecewise_linear_table_interpolator_unit] ERROR");
		$finish;
	end

	// Result side readiness: random bursts plus two long hold-offs
	initial begin : result_sink
		int unsigned hold_stage;
		int unsigned hold_points [2];
		hold_points = '{40, 400};
		hold_stage = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_stage < 2 && results_seen >= hold_points[hold_stage]) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_stage++;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7) - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin : check_results
		interp_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual value %h status %0d",
					$time, m_tdata, m_tuser);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata !== want.value) begin
					$display("%0t: result_value mismatch: expected %h, actual %h",
						$time, want.value, m_tdata);
					fail_count++;
				end
				if (m_tuser !== want.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, want.status, m_tuser);
					fail_count++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		#(64'd12_000_000);
		$display("[piecewise_linear_table_interpolator_unit] ERROR");
		$finish;
	end

endmodule
